### rtl/core/particle_wall_integrator_core_defines.svh
// Assertion macros shared by the particle integrator checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef PARTICLE_WALL_INTEGRATOR_CORE_DEFINES_SVH
`define PARTICLE_WALL_INTEGRATOR_CORE_DEFINES_SVH

// implication checked only while out of reset
`define PWI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define PWI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pwi_pkg.sv
// Types, register codes, reset values and helpers for the particle integrator.
// No dependencies.
package pwi_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
  } out_t;

  localparam logic [2:0] REG_WALL_HIGH_X    = 3'd0;
  localparam logic [2:0] REG_WALL_HIGH_Y    = 3'd1;
  localparam logic [2:0] REG_WALL_HIGH_Z    = 3'd2;
  localparam logic [2:0] REG_WALL_MARGIN    = 3'd3;
  localparam logic [2:0] REG_ACCEL_LIMIT    = 3'd4;
  localparam logic [2:0] REG_WALL_STIFFNESS = 3'd5;
  localparam logic [2:0] REG_WALL_DAMPING   = 3'd6;
  localparam logic [2:0] REG_TIME_STEP      = 3'd7;

  localparam logic [30:0] RST_WALL_HIGH_X    = 31'd6553600;
  localparam logic [30:0] RST_WALL_HIGH_Y    = 31'd1966080;
  localparam logic [30:0] RST_WALL_HIGH_Z    = 31'd6553600;
  localparam logic [30:0] RST_WALL_MARGIN    = 31'd131072;
  localparam logic [30:0] RST_ACCEL_LIMIT    = 31'd5120000;
  localparam logic [15:0] RST_WALL_STIFFNESS = 16'd10000;
  localparam logic [15:0] RST_WALL_DAMPING   = 16'd256;
  localparam logic [31:0] RST_TIME_STEP      = 32'd429497;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  // register stages from the accepting edge to out_valid
  localparam int LATENCY    = 75;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

### rtl/core/pwi_accel_limit.sv
// Acceleration magnitude limiter: squares, pipelined integer square root,
// pipelined restoring dividers. Depends on pwi_pkg.
module pwi_accel_limit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pwi_pkg::in_t  in_data,
  input  logic [30:0]   accel_limit,
  output logic          out_valid,
  output pwi_pkg::in_t  out_data
);

  localparam int NS = pwi_pkg::SQRT_STEPS;
  localparam int ND = pwi_pkg::DIV_STEPS;

  logic signed [31:0] a_in [3];
  assign a_in[0] = in_data.accel_x;
  assign a_in[1] = in_data.accel_y;
  assign a_in[2] = in_data.accel_z;

  // stage 1: magnitudes
  logic         v1_r;
  pwi_pkg::in_t d1_r;
  logic [31:0]  m1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_valid;
    d1_r <= in_data;
    for (int j = 0; j < 3; j++) begin
      m1_r[j] <= a_in[j][31] ? (~a_in[j] + 32'd1) : a_in[j];
    end
  end

  // stage 2: squares
  logic         v2_r;
  pwi_pkg::in_t d2_r;
  logic [31:0]  m2_r [3];
  logic [63:0]  sq2_r [3];
  logic [61:0]  lim2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    d2_r   <= d1_r;
    lim2_r <= accel_limit * accel_limit;
    for (int j = 0; j < 3; j++) begin
      m2_r[j]  <= m1_r[j];
      sq2_r[j] <= m1_r[j] * m1_r[j];
    end
  end

  // stage 3 (sqrt slot 0): sum and compare
  logic         sv_r    [NS+1];
  pwi_pkg::in_t sd_r    [NS+1];
  logic [31:0]  sm_r    [NS+1][3];
  logic         sneed_r [NS+1];
  logic [63:0]  sn_r    [NS+1];
  logic [63:0]  sr_r    [NS+1];

  logic [63:0] ssum;
  assign ssum = sq2_r[0] + sq2_r[1] + sq2_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else        sv_r[0] <= v2_r;
    sd_r[0]    <= d2_r;
    sneed_r[0] <= ssum > {2'b00, lim2_r};
    sn_r[0]    <= ssum;
    sr_r[0]    <= '0;
    for (int j = 0; j < 3; j++) sm_r[0][j] <= m2_r[j];
  end

  // one root bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;
    assign trial = sr_r[k] + BIT;
    assign take  = sn_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else        sv_r[k+1] <= sv_r[k];
      sd_r[k+1]    <= sd_r[k];
      sneed_r[k+1] <= sneed_r[k];
      for (int j = 0; j < 3; j++) sm_r[k+1][j] <= sm_r[k][j];
      if (take) begin
        sn_r[k+1] <= sn_r[k] - trial;
        sr_r[k+1] <= (sr_r[k] >> 1) + BIT;
      end else begin
        sn_r[k+1] <= sn_r[k];
        sr_r[k+1] <= sr_r[k] >> 1;
      end
    end
  end

  // divider slot 0: numerators m * limit
  logic         dv_r    [ND+1];
  pwi_pkg::in_t dd_r    [ND+1];
  logic         dneed_r [ND+1];
  logic [31:0]  droot_r [ND+1];
  logic [62:0]  drem_r  [ND+1][3];
  logic [30:0]  dq_r    [ND+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= sv_r[NS];
    dd_r[0]    <= sd_r[NS];
    dneed_r[0] <= sneed_r[NS];
    droot_r[0] <= sr_r[NS][31:0];
    for (int j = 0; j < 3; j++) begin
      drem_r[0][j] <= sm_r[NS][j] * accel_limit;
      dq_r[0][j]   <= '0;
    end
  end

  // one quotient bit per stage, quotient does not exceed the limit when the root is non-zero
  for (genvar i = 0; i < ND; i++) begin : g_div
    localparam int BITPOS = ND - 1 - i;
    logic [62:0] dshift;
    assign dshift = 63'(droot_r[i]) << BITPOS;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[i+1] <= 1'b0;
      else        dv_r[i+1] <= dv_r[i];
      dd_r[i+1]    <= dd_r[i];
      dneed_r[i+1] <= dneed_r[i];
      droot_r[i+1] <= droot_r[i];
      for (int j = 0; j < 3; j++) begin
        if (drem_r[i][j] >= dshift) begin
          drem_r[i+1][j] <= drem_r[i][j] - dshift;
          dq_r[i+1][j]   <= dq_r[i][j] | (31'd1 << BITPOS);
        end else begin
          drem_r[i+1][j] <= drem_r[i][j];
          dq_r[i+1][j]   <= dq_r[i][j];
        end
      end
    end
  end

  // restore signs and pick limited or original components
  logic signed [31:0] a_lim [3];
  logic signed [31:0] a_org [3];
  pwi_pkg::in_t       od_nxt;
  assign a_org[0] = dd_r[ND].accel_x;
  assign a_org[1] = dd_r[ND].accel_y;
  assign a_org[2] = dd_r[ND].accel_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!dneed_r[ND])       a_lim[j] = a_org[j];
      else if (a_org[j][31])  a_lim[j] = -$signed({1'b0, dq_r[ND][j]});
      else                    a_lim[j] = $signed({1'b0, dq_r[ND][j]});
    end
    od_nxt         = dd_r[ND];
    od_nxt.accel_x = a_lim[0];
    od_nxt.accel_y = a_lim[1];
    od_nxt.accel_z = a_lim[2];
  end

  logic         ov_r;
  pwi_pkg::in_t od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= dv_r[ND];
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

### rtl/core/particle_wall_integrator_core.sv
// Particle integrator top level: registers, wall penalty and Euler step.
// Depends on pwi_pkg and pwi_accel_limit.
// out_valid follows the edge that takes a word through the input register, the limiter and stages W1 to E4.
// Throughput: one particle per cycle; busy stays low, the pipeline never stalls.
// The square root and the divide run one bit per stage, which sets the depth.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module particle_wall_integrator_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pwi_pkg::in_t  in_data,
  output logic          out_valid,
  output pwi_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic [30:0] wall_high_r [3];
  logic [30:0] wall_margin_r;
  logic [30:0] accel_limit_r;
  logic [15:0] wall_stiffness_r;
  logic [15:0] wall_damping_r;
  logic [31:0] time_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_high_r[0]   <= pwi_pkg::RST_WALL_HIGH_X;
      wall_high_r[1]   <= pwi_pkg::RST_WALL_HIGH_Y;
      wall_high_r[2]   <= pwi_pkg::RST_WALL_HIGH_Z;
      wall_margin_r    <= pwi_pkg::RST_WALL_MARGIN;
      accel_limit_r    <= pwi_pkg::RST_ACCEL_LIMIT;
      wall_stiffness_r <= pwi_pkg::RST_WALL_STIFFNESS;
      wall_damping_r   <= pwi_pkg::RST_WALL_DAMPING;
      time_step_r      <= pwi_pkg::RST_TIME_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        pwi_pkg::REG_WALL_HIGH_X:    wall_high_r[0]   <= cfg_data[30:0];
        pwi_pkg::REG_WALL_HIGH_Y:    wall_high_r[1]   <= cfg_data[30:0];
        pwi_pkg::REG_WALL_HIGH_Z:    wall_high_r[2]   <= cfg_data[30:0];
        pwi_pkg::REG_WALL_MARGIN:    wall_margin_r    <= cfg_data[30:0];
        pwi_pkg::REG_ACCEL_LIMIT:    accel_limit_r    <= cfg_data[30:0];
        pwi_pkg::REG_WALL_STIFFNESS: wall_stiffness_r <= cfg_data[15:0];
        pwi_pkg::REG_WALL_DAMPING:   wall_damping_r   <= cfg_data[15:0];
        pwi_pkg::REG_TIME_STEP:      time_step_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input word register
  logic         in_valid_r;
  pwi_pkg::in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else        in_valid_r <= start && !busy;
    in_r <= in_data;
  end

  logic         lim_valid;
  pwi_pkg::in_t lim_data;

  pwi_accel_limit u_limit (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid_r),
    .in_data     (in_r),
    .accel_limit (accel_limit_r),
    .out_valid   (lim_valid),
    .out_data    (lim_data)
  );

  logic signed [31:0] lp [3];
  logic signed [31:0] lv [3];
  logic signed [31:0] la [3];
  assign lp[0] = lim_data.pos_x;
  assign lp[1] = lim_data.pos_y;
  assign lp[2] = lim_data.pos_z;
  assign lv[0] = lim_data.vel_x;
  assign lv[1] = lim_data.vel_y;
  assign lv[2] = lim_data.vel_z;
  assign la[0] = lim_data.accel_x;
  assign la[1] = lim_data.accel_y;
  assign la[2] = lim_data.accel_z;

  // W1: wall tests and penalty products
  logic signed [33:0] marg;
  logic signed [33:0] dh   [3];
  logic               hnear [3];
  logic               lnear [3];
  logic signed [33:0] pen  [3];
  assign marg = $signed({3'b000, wall_margin_r});

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dh[j]    = $signed({3'b000, wall_high_r[j]}) - 34'(lp[j]);
      hnear[j] = dh[j] < marg;
      lnear[j] = 34'(lp[j]) < marg;
      pen[j]   = hnear[j] ? (marg - dh[j]) : (marg - 34'(lp[j]));
    end
  end

  logic               w1_valid_r;
  logic signed [31:0] w1_p_r [3];
  logic signed [31:0] w1_v_r [3];
  logic signed [31:0] w1_a_r [3];
  logic               w1_hi_r [3];
  logic               w1_lo_r [3];
  logic signed [50:0] w1_kpen_r [3];
  logic signed [48:0] w1_dv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) w1_valid_r <= 1'b0;
    else        w1_valid_r <= lim_valid;
    for (int j = 0; j < 3; j++) begin
      w1_p_r[j]    <= lp[j];
      w1_v_r[j]    <= lv[j];
      w1_a_r[j]    <= la[j];
      w1_hi_r[j]   <= hnear[j];
      w1_lo_r[j]   <= lnear[j];
      w1_kpen_r[j] <= $signed({1'b0, wall_stiffness_r}) * pen[j];
      w1_dv_r[j]   <= $signed({1'b0, wall_damping_r}) * lv[j];
    end
  end

  // W2: combine penalty, drop fraction, saturate; high wall wins
  logic signed [52:0] wacc [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wacc[j] = 53'(w1_a_r[j]) <<< 8;
      if (w1_hi_r[j]) begin
        wacc[j] = wacc[j] - 53'(w1_kpen_r[j]) - 53'(w1_dv_r[j]);
      end else if (w1_lo_r[j]) begin
        wacc[j] = wacc[j] + 53'(w1_kpen_r[j]) - 53'(w1_dv_r[j]);
      end
    end
  end

  logic               w2_valid_r;
  logic signed [31:0] w2_p_r [3];
  logic signed [31:0] w2_v_r [3];
  logic signed [31:0] w2_a_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) w2_valid_r <= 1'b0;
    else        w2_valid_r <= w1_valid_r;
    for (int j = 0; j < 3; j++) begin
      w2_p_r[j] <= w1_p_r[j];
      w2_v_r[j] <= w1_v_r[j];
      w2_a_r[j] <= pwi_pkg::sat32(64'(wacc[j] >>> 8));
    end
  end

  logic signed [32:0] dts;
  assign dts = $signed({1'b0, time_step_r});

  // E1: a * dt
  logic               e1_valid_r;
  logic signed [31:0] e1_p_r [3];
  logic signed [31:0] e1_v_r [3];
  logic signed [64:0] e1_prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) e1_valid_r <= 1'b0;
    else        e1_valid_r <= w2_valid_r;
    for (int j = 0; j < 3; j++) begin
      e1_p_r[j]    <= w2_p_r[j];
      e1_v_r[j]    <= w2_v_r[j];
      e1_prod_r[j] <= 65'(w2_a_r[j]) * 65'(dts);
    end
  end

  // E2: new velocity
  logic signed [40:0] dvel [3];
  always_comb begin
    for (int j = 0; j < 3; j++) dvel[j] = 41'(e1_prod_r[j] >>> 24);
  end

  logic               e2_valid_r;
  logic signed [31:0] e2_p_r [3];
  logic signed [31:0] e2_nv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) e2_valid_r <= 1'b0;
    else        e2_valid_r <= e1_valid_r;
    for (int j = 0; j < 3; j++) begin
      e2_p_r[j]  <= e1_p_r[j];
      e2_nv_r[j] <= pwi_pkg::sat32(64'(e1_v_r[j]) + 64'(dvel[j]));
    end
  end

  // E3: v' * dt
  logic               e3_valid_r;
  logic signed [31:0] e3_p_r [3];
  logic signed [31:0] e3_nv_r [3];
  logic signed [64:0] e3_prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) e3_valid_r <= 1'b0;
    else        e3_valid_r <= e2_valid_r;
    for (int j = 0; j < 3; j++) begin
      e3_p_r[j]    <= e2_p_r[j];
      e3_nv_r[j]   <= e2_nv_r[j];
      e3_prod_r[j] <= 65'(e2_nv_r[j]) * 65'(dts);
    end
  end

  // E4: new position, output register
  logic signed [32:0] dpos [3];
  always_comb begin
    for (int j = 0; j < 3; j++) dpos[j] = 33'(e3_prod_r[j] >>> 32);
  end

  logic               out_valid_r;
  logic signed [31:0] np_r [3];
  logic signed [31:0] nv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= e3_valid_r;
    for (int j = 0; j < 3; j++) begin
      nv_r[j] <= e3_nv_r[j];
      np_r[j] <= pwi_pkg::sat32(64'(e3_p_r[j]) + 64'(dpos[j]));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.new_pos_x = np_r[0];
  assign out_data.new_pos_y = np_r[1];
  assign out_data.new_pos_z = np_r[2];
  assign out_data.new_vel_x = nv_r[0];
  assign out_data.new_vel_y = nv_r[1];
  assign out_data.new_vel_z = nv_r[2];

endmodule

### rtl/core/pwi_checker.sv
// Port-level checks for the particle integrator, bound to the top level.
// Depends on pwi_pkg and particle_wall_integrator_core_defines.svh.
`include "particle_wall_integrator_core_defines.svh"

module pwi_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `PWI_ASSERT_IMPL(a_never_busy, 1'b1, !busy, "busy raised on a stall-free pipeline")
  `PWI_ASSERT_IMPL(a_out_from_word, out_valid, $past(start && !busy, pwi_pkg::LATENCY), "result without a word taken at the pipeline depth")
  `PWI_ASSERT_NEXT(a_reset_flush, !rst_n, !out_valid, "result strobe after reset")

endmodule

bind particle_wall_integrator_core pwi_checker u_pwi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

### tb/sv/particle_wall_integrator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for particle_wall_integrator_core: wall penalty, accel cap, Euler step.
// Depends on pwi_pkg and the core; an in-bench predictor checks every output word.
module particle_wall_integrator_core_tb;
  import pwi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  // shadow copy of the register file
  logic [30:0] hi_x, hi_y, hi_z, margin_r, limit_r;
  logic [15:0] stiff_r, damp_r;
  logic [31:0] dt_r;

  out_t pending_q[$];
  int errors;
  int cycles;

  particle_wall_integrator_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[particle_wall_integrator_core] ERROR");
      $finish;
    end
  end

  function automatic longint sat_word(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic out_t advance_particle(input in_t w);
    longint p[3], v[3], a[3], hw[3];
    logic [63:0] mag[3];
    logic [63:0] ssq, lim, root;
    longint acc, mg, k, d, dt, nv, np;
    out_t res;
    p[0] = w.pos_x;   p[1] = w.pos_y;   p[2] = w.pos_z;
    v[0] = w.vel_x;   v[1] = w.vel_y;   v[2] = w.vel_z;
    a[0] = w.accel_x; a[1] = w.accel_y; a[2] = w.accel_z;
    hw[0] = longint'(hi_x); hw[1] = longint'(hi_y); hw[2] = longint'(hi_z);
    lim = 64'(limit_r);
    ssq = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = (a[j] < 0) ? 64'(-a[j]) : 64'(a[j]);
      ssq = ssq + mag[j] * mag[j];
    end
    // cap magnitude, keep direction
    if (ssq > lim * lim) begin
      root = int_sqrt(ssq);
      for (int j = 0; j < 3; j++)
        a[j] = (a[j] < 0) ? -longint'((mag[j] * lim) / root) : longint'((mag[j] * lim) / root);
    end
    mg = longint'(margin_r);
    k = longint'(stiff_r);
    d = longint'(damp_r);
    dt = longint'(dt_r);
    for (int j = 0; j < 3; j++) begin
      acc = a[j] * 256;
      // high wall takes priority over the low wall
      if (hw[j] - p[j] < mg) begin
        acc = acc - k * (mg - (hw[j] - p[j])) - d * v[j];
      end else if (p[j] < mg) begin
        acc = acc + k * (mg - p[j]) - d * v[j];
      end
      a[j] = sat_word(acc >>> 8);
    end
    for (int j = 0; j < 3; j++) begin
      nv = sat_word(v[j] + ((a[j] * dt) >>> 24));
      np = sat_word(p[j] + ((nv * dt) >>> 32));
      case (j)
        0: begin res.new_pos_x = np[31:0]; res.new_vel_x = nv[31:0]; end
        1: begin res.new_pos_y = np[31:0]; res.new_vel_y = nv[31:0]; end
        default: begin res.new_pos_z = np[31:0]; res.new_vel_z = nv[31:0]; end
      endcase
    end
    return res;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s expected %h actual %h", $time, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_t exp_w;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word expected none actual %h", $time, out_data);
      end else begin
        exp_w = pending_q.pop_front();
        check_field("new_pos_x", exp_w.new_pos_x, out_data.new_pos_x);
        check_field("new_pos_y", exp_w.new_pos_y, out_data.new_pos_y);
        check_field("new_pos_z", exp_w.new_pos_z, out_data.new_pos_z);
        check_field("new_vel_x", exp_w.new_vel_x, out_data.new_vel_x);
        check_field("new_vel_y", exp_w.new_vel_y, out_data.new_vel_y);
        check_field("new_vel_z", exp_w.new_vel_z, out_data.new_vel_z);
      end
    end
  end

  task automatic send_particle(input in_t w);
    int gap;
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    pending_q.insert(pending_q.size(), advance_particle(w));
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the write enable; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_WALL_HIGH_X:    hi_x = val[30:0];
      REG_WALL_HIGH_Y:    hi_y = val[30:0];
      REG_WALL_HIGH_Z:    hi_z = val[30:0];
      REG_WALL_MARGIN:    margin_r = val[30:0];
      REG_ACCEL_LIMIT:    limit_r = val[30:0];
      REG_WALL_STIFFNESS: stiff_r = val[15:0];
      REG_WALL_DAMPING:   damp_r = val[15:0];
      REG_TIME_STEP:      dt_r = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] hx, hy, hz, mg, lim, k, d, dt);
    drain();
    write_reg(REG_WALL_HIGH_X, hx);
    write_reg(REG_WALL_HIGH_Y, hy);
    write_reg(REG_WALL_HIGH_Z, hz);
    write_reg(REG_WALL_MARGIN, mg);
    write_reg(REG_ACCEL_LIMIT, lim);
    write_reg(REG_WALL_STIFFNESS, k);
    write_reg(REG_WALL_DAMPING, d);
    write_reg(REG_TIME_STEP, dt);
    cfg_we <= 1'b0;
  endtask

  function automatic in_t make_particle(input logic [31:0] px, py, pz, vx, vy, vz,
                                        input logic [31:0] ax, ay, az);
    in_t w;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    w.vel_x = vx; w.vel_y = vy; w.vel_z = vz;
    w.accel_x = ax; w.accel_y = ay; w.accel_z = az;
    return w;
  endfunction

  // position drawn mostly close to one of the walls on that axis
  function automatic logic [31:0] rand_pos(input logic [30:0] hw);
    int sel;
    logic [31:0] off;
    sel = $urandom_range(0, 9);
    off = 32'($urandom_range(0, 2 * margin_r + 16)) - 32'(margin_r);
    if (margin_r > 31'h3fff_0000) off = $urandom;
    case (sel)
      0, 1:    return $urandom;
      2, 3, 4: return off + 32'(margin_r);
      5, 6, 7: return 32'(hw) - off;
      default: return $urandom_range(0, hw);
    endcase
  endfunction

  function automatic logic [31:0] rand_val(input int bigness);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * bigness)) - bigness);
  endfunction

  function automatic in_t rand_particle;
    return make_particle(rand_pos(hi_x), rand_pos(hi_y), rand_pos(hi_z),
                         rand_val(1 << 20), rand_val(1 << 20), rand_val(1 << 20),
                         rand_val(1 << 24), rand_val(1 << 24), rand_val(1 << 24));
  endfunction

  task automatic test_field_extremes;
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_particle(make_particle(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_particle(make_particle(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_particle(make_particle(mx, mn, mx, mn, mx, mn, mx, mn, mx));
    send_particle(make_particle(32'hffffffff, 1, 32'hffffffff, 1, 32'hffffffff, 1,
                                32'hffffffff, 1, 32'hffffffff));
  endtask

  task automatic test_accel_cap;
    // at and just over the cap on one axis, then a three-axis vector over it
    send_particle(make_particle(32'h0020_0000, 32'h0010_0000, 32'h0020_0000, 0, 0, 0,
                                5120000, 0, 0));
    send_particle(make_particle(32'h0020_0000, 32'h0010_0000, 32'h0020_0000, 0, 0, 0,
                                5120001, 0, 0));
    send_particle(make_particle(32'h0020_0000, 32'h0010_0000, 32'h0020_0000, 0, 0, 0,
                                -4000000, 4000000, -4000000));
    load_config(RST_WALL_HIGH_X, RST_WALL_HIGH_Y, RST_WALL_HIGH_Z, RST_WALL_MARGIN,
                0, RST_WALL_STIFFNESS, RST_WALL_DAMPING, RST_TIME_STEP);
    send_particle(make_particle(32'h0020_0000, 32'h0010_0000, 32'h0020_0000, 5, 5, 5,
                                1, -1, 300));
    send_particle(make_particle(32'h0020_0000, 32'h0010_0000, 32'h0020_0000, 5, 5, 5,
                                0, 0, 0));
    load_config(RST_WALL_HIGH_X, RST_WALL_HIGH_Y, RST_WALL_HIGH_Z, RST_WALL_MARGIN,
                32'h7fffffff, RST_WALL_STIFFNESS, RST_WALL_DAMPING, 32'hffffffff);
    send_particle(make_particle(32'h0020_0000, 32'h0010_0000, 32'h0020_0000, 0, 0, 0,
                                32'h80000000, 32'h80000000, 32'h80000000));
  endtask

  task automatic test_wall_zones;
    load_config(RST_WALL_HIGH_X, RST_WALL_HIGH_Y, RST_WALL_HIGH_Z, RST_WALL_MARGIN,
                RST_ACCEL_LIMIT, RST_WALL_STIFFNESS, RST_WALL_DAMPING, RST_TIME_STEP);
    // inside low margin, at low wall, below it, near high wall, at high wall
    send_particle(make_particle(32'h0001_0000, 0, -32'sd65536, 32'h100, -32'sd256, 32'h100,
                                1000, -1000, 0));
    send_particle(make_particle(32'd6553600 - 32'h0001_0000, 32'd1966080, 32'd1966080 + 500,
                                -32'sd70000, 70000, 3, 0, 0, 0));
    send_particle(make_particle(32'd131072, 32'd1966080 - 32'd131072, 32'd131071,
                                0, 0, 0, 0, 0, 0));
    // walls so close both margins overlap: high wall wins
    load_config(32'h0001_0000, 32'h0001_0000, 0, 32'h0004_0000, RST_ACCEL_LIMIT,
                16'hffff, 16'hffff, RST_TIME_STEP);
    send_particle(make_particle(32'h8000, 32'h0, 32'h0, 32'h0100_0000, -32'sd16777216, 7,
                                0, 0, 0));
    send_particle(make_particle(32'h80000000, 32'h7fffffff, 32'h8000, 32'h7fffffff,
                                32'h80000000, -32'sd7, 32'h7fffffff, 0, 32'h80000000));
    load_config(0, 0, 0, 0, RST_ACCEL_LIMIT, 0, 0, 0);
    send_particle(make_particle(0, 32'hffffffff, 1, 12345, -12345, 0, 99, -99, 0));
    send_particle(make_particle(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_phase(input int count);
    repeat (count) send_particle(rand_particle());
  endtask

  task automatic test_random_configs;
    // reset-like setup first, then widely varied ones
    load_config(RST_WALL_HIGH_X, RST_WALL_HIGH_Y, RST_WALL_HIGH_Z, RST_WALL_MARGIN,
                RST_ACCEL_LIMIT, RST_WALL_STIFFNESS, RST_WALL_DAMPING, RST_TIME_STEP);
    test_random_phase(225);
    load_config(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                16'hffff, 16'hffff, 32'hffffffff);
    test_random_phase(225);
    load_config(32'hffffffff, 32'h8000_0000, 32'h4000_0000, 32'h8000_0000, 32'hffffffff,
                32'hffff_0001, 32'hffff_fffe, 32'h8000_0000);
    test_random_phase(225);
    repeat (3) begin
      load_config($urandom, $urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0100_0000),
                  $urandom_range(0, 32'h0004_0000), $urandom, $urandom, $urandom, $urandom);
      test_random_phase(225);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WALL_HIGH_X;
    cfg_data = '0;
    hi_x = RST_WALL_HIGH_X;
    hi_y = RST_WALL_HIGH_Y;
    hi_z = RST_WALL_HIGH_Z;
    margin_r = RST_WALL_MARGIN;
    limit_r = RST_ACCEL_LIMIT;
    stiff_r = RST_WALL_STIFFNESS;
    damp_r = RST_WALL_DAMPING;
    dt_r = RST_TIME_STEP;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_accel_cap();
    test_wall_zones();
    test_random_configs();

    start <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("[particle_wall_integrator_core] OK");
    end else begin
      $display("[particle_wall_integrator_core] ERROR");
    end
    $finish;
  end

endmodule
